// File: rtl/ats_pkg.sv
`default_nettype none

package ats_pkg;

	localparam int TIMER_BITS_DEF = 16;
	localparam int CFG_IDX_W      = 8;
	localparam int CFG_DATA_W     = 16;
	localparam int IN_DATA_W      = 8;
	localparam int OUT_DATA_W     = 32;

	typedef enum logic [1:0] {
		MODE_CONFIRM = 2'd0,
		MODE_HOUR    = 2'd1,
		MODE_MINUTE  = 2'd2,
		MODE_ARMED   = 2'd3
	} mode_t;

	localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS   = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT       = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COMBO        = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LOCKOUT      = 8'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MINUTE_STEP  = 8'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SAVED_VALID  = 8'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SAVED_HOUR   = 8'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SAVED_MINUTE = 8'd7;

	localparam logic [15:0] LONG_PRESS_RST = 16'd500;
	localparam logic [15:0] REPEAT_RST     = 16'd120;
	localparam logic [15:0] COMBO_RST      = 16'd150;
	localparam logic [15:0] LOCKOUT_RST    = 16'd300;
	localparam logic [4:0]  STEP_RST       = 5'd5;
	localparam logic [4:0]  HOUR_RST       = 5'd7;
	localparam logic [5:0]  MINUTE_RST     = 6'd0;
	localparam logic [4:0]  HOURS_PER_DAY  = 5'd24;
	localparam logic [5:0]  MINS_PER_HOUR  = 6'd60;

	typedef struct packed {
		logic held;
		logic restart;
		logic act;
	} key_res_t;

endpackage

`default_nettype wire

// File: rtl/ats_key.sv
`default_nettype none

module ats_key #(
	parameter int TIMER_BITS = ats_pkg::TIMER_BITS_DEF
) (
	input  logic                  down,
	input  logic                  other_down,
	input  logic                  held,
	input  logic [TIMER_BITS-1:0] hold_age,
	input  logic [TIMER_BITS-1:0] since_action,
	input  logic [15:0]           long_press_ms,
	input  logic [15:0]           repeat_ms,
	output ats_pkg::key_res_t     res
);
	import ats_pkg::*;

	localparam int CW = (TIMER_BITS > 16) ? TIMER_BITS : 16;

	logic repeat_due;

	assign repeat_due = (CW'(hold_age) > CW'(long_press_ms)) &&
		(CW'(since_action) > CW'(repeat_ms));

	always_comb begin
		res      = '0;
		res.held = held;
		if (!other_down) begin
			if (!down) begin
				res.held = 1'b0;
			end else if (!held) begin
				res.held    = 1'b1;
				res.restart = 1'b1;
				res.act     = 1'b1;
			end else if (repeat_due) begin
				res.act = 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/alarm_time_setter_with_key_repeat.sv
`default_nettype none

// Alarm time setter driven by one button sample per millisecond tick.
// The input stream carries one beat per tick: s_tdata bit 0 is plus, bit 1 is
// minus and bit 2 is enter, 1 meaning pressed. Every input beat produces exactly
// one output beat holding the mode, the committed and edited alarm time, the
// enable flag and the combo, armed and store pulses of that tick.
// The configuration channel writes timing thresholds, the minute step and the
// stored alarm; writing saved_valid reloads the start-up state. It is always
// ready and should be used only while no beats are in flight.
// An accepted beat's result is registered in the output entry, or in the skid
// entry while the output entry is full. Throughput is one beat per cycle unless
// the receiver stalls, set by the single tick update between state and output registers.
// The output side has a two-entry buffer, so one more beat is taken while the
// receiver stalls; s_tready then drops until the receiver drains a beat.
// Reset clears both buffers and loads the default thresholds with no stored
// alarm, so the block starts in hour setting at 07:00.
module alarm_time_setter_with_key_repeat #(
	parameter int TIMER_BITS = ats_pkg::TIMER_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// plus_down, minus_down, enter_down, zero fill
	input  logic [ats_pkg::IN_DATA_W-1:0]  s_tdata,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// mode, alarm_hour, alarm_minute, edit_hour, edit_minute, alarm_on,
	// combo_pulse, armed_pulse, store_pulse, zero fill
	output logic [ats_pkg::OUT_DATA_W-1:0] m_tdata,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [ats_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ats_pkg::CFG_DATA_W-1:0] cfg_data
);
	import ats_pkg::*;

	localparam int CW = (TIMER_BITS > 16) ? TIMER_BITS : 16;
	localparam logic [TIMER_BITS-1:0] TMAX = '1;

	logic [15:0] long_press_q, repeat_q, combo_ms_q, lockout_q;
	logic [4:0]  step_q, saved_hour_q;
	logic [5:0]  saved_minute_q;

	mode_t       mode_q, mode_d;
	logic [4:0]  alarm_hour_q, alarm_hour_d, edit_hour_q, edit_hour_d;
	logic [5:0]  alarm_minute_q, alarm_minute_d, edit_minute_q, edit_minute_d;
	logic        alarm_on_q, alarm_on_d;
	logic        plus_held_q, plus_held_d, minus_held_q, minus_held_d;
	logic        ewr_q, ewr_d, combo_held_q, combo_held_d, combo_done_q, combo_done_d;
	logic [TIMER_BITS-1:0] plus_age_q, plus_age_d, minus_age_q, minus_age_d;
	logic [TIMER_BITS-1:0] since_action_q, since_action_d, since_enter_q, since_enter_d;
	logic [TIMER_BITS-1:0] combo_age_q, combo_age_d;
	logic [TIMER_BITS-1:0] pa, ma, sa, se, ca, sa_minus;

	logic        m_tvalid_q, sk_valid_q;
	logic [OUT_DATA_W-1:0] m_data_q, sk_data_q, result;

	logic        pd, md, ed, push, pop, cfg_we, reload, reload_valid;
	logic        frozen, armed, fired, active, ap, am, enter_ok;
	logic        combo_p, armed_p, store_p;
	key_res_t    kp, km;
	logic [6:0]  min_up, min_dn;
	logic [5:0]  min_up_w, min_dn_w, ld_minute;
	logic [4:0]  hour_up, hour_dn, ld_hour;

	assign pd = s_tdata[0];
	assign md = s_tdata[1];
	assign ed = s_tdata[2];

	assign s_tready  = !sk_valid_q;
	assign push      = s_tvalid && s_tready;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_data_q;
	assign pop       = m_tvalid_q && m_tready;
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;
	assign reload    = cfg_we && (cfg_index == REG_SAVED_VALID);
	assign reload_valid = cfg_data[0];

	assign ld_hour   = (saved_hour_q >= HOURS_PER_DAY) ? saved_hour_q - HOURS_PER_DAY
		: saved_hour_q;
	assign ld_minute = (saved_minute_q >= MINS_PER_HOUR) ? saved_minute_q - MINS_PER_HOUR
		: saved_minute_q;

	assign pa = (plus_age_q == TMAX) ? TMAX : plus_age_q + 1'b1;
	assign ma = (minus_age_q == TMAX) ? TMAX : minus_age_q + 1'b1;
	assign sa = (since_action_q == TMAX) ? TMAX : since_action_q + 1'b1;
	assign se = (since_enter_q == TMAX) ? TMAX : since_enter_q + 1'b1;
	assign ca = (combo_age_q == TMAX) ? TMAX : combo_age_q + 1'b1;

	assign frozen = ewr_q && ed;
	assign armed  = (mode_q == MODE_ARMED);

	always_comb begin
		combo_held_d = combo_held_q;
		combo_done_d = combo_done_q;
		combo_age_d  = ca;
		fired        = 1'b0;
		if (!frozen && armed) begin
			if (pd && md) begin
				if (!combo_held_q) begin
					combo_held_d = 1'b1;
					combo_age_d  = '0;
				end
				if (!combo_done_q && (CW'(combo_age_d) >= CW'(combo_ms_q))) begin
					combo_done_d = 1'b1;
					fired        = 1'b1;
				end
			end else begin
				combo_held_d = 1'b0;
				combo_done_d = 1'b0;
			end
		end
	end

	assign active = !frozen && !fired;

	ats_key #(.TIMER_BITS(TIMER_BITS)) u_plus (
		.down(pd), .other_down(md), .held(plus_held_q), .hold_age(pa),
		.since_action(sa), .long_press_ms(long_press_q), .repeat_ms(repeat_q), .res(kp)
	);

	assign sa_minus = kp.act ? '0 : sa;

	ats_key #(.TIMER_BITS(TIMER_BITS)) u_minus (
		.down(md), .other_down(pd), .held(minus_held_q), .hold_age(ma),
		.since_action(sa_minus), .long_press_ms(long_press_q), .repeat_ms(repeat_q),
		.res(km)
	);

	assign ap = active && kp.act;
	assign am = active && km.act;
	assign enter_ok = active && !ap && !am && !armed && ed &&
		(CW'(se) > CW'(lockout_q));

	assign plus_held_d    = frozen ? plus_held_q : (fired ? 1'b0 : kp.held);
	assign minus_held_d   = frozen ? minus_held_q : (fired ? 1'b0 : km.held);
	assign plus_age_d     = (active && kp.restart) ? '0 : pa;
	assign minus_age_d    = (active && km.restart) ? '0 : ma;
	assign since_action_d = (ap || am) ? '0 : sa;
	assign since_enter_d  = enter_ok ? '0 : se;
	assign ewr_d          = frozen || enter_ok;

	assign hour_up  = (edit_hour_q == HOURS_PER_DAY - 5'd1) ? 5'd0 : edit_hour_q + 5'd1;
	assign hour_dn  = (edit_hour_q == 5'd0) ? HOURS_PER_DAY - 5'd1 : edit_hour_q - 5'd1;
	assign min_up   = {1'b0, edit_minute_q} + {2'b00, step_q};
	assign min_dn   = {1'b0, edit_minute_q} + {1'b0, MINS_PER_HOUR} - {2'b00, step_q};
	assign min_up_w = (min_up >= {1'b0, MINS_PER_HOUR}) ?
		6'(min_up - {1'b0, MINS_PER_HOUR}) : min_up[5:0];
	assign min_dn_w = (min_dn >= {1'b0, MINS_PER_HOUR}) ?
		6'(min_dn - {1'b0, MINS_PER_HOUR}) : min_dn[5:0];

	always_comb begin
		mode_d         = mode_q;
		alarm_hour_d   = alarm_hour_q;
		alarm_minute_d = alarm_minute_q;
		edit_hour_d    = edit_hour_q;
		edit_minute_d  = edit_minute_q;
		alarm_on_d     = alarm_on_q;
		unique case (mode_q)
			MODE_CONFIRM: begin
				if (ap || am) begin
					edit_hour_d   = alarm_hour_q;
					edit_minute_d = alarm_minute_q;
					mode_d        = MODE_HOUR;
				end else if (enter_ok) begin
					alarm_on_d = 1'b1;
					mode_d     = MODE_ARMED;
				end
			end
			MODE_HOUR: begin
				if (ap) begin
					edit_hour_d = hour_up;
				end else if (am) begin
					edit_hour_d = hour_dn;
				end else if (enter_ok) begin
					alarm_hour_d = edit_hour_q;
					mode_d       = MODE_MINUTE;
				end
			end
			MODE_MINUTE: begin
				if (ap) begin
					edit_minute_d = min_up_w;
				end else if (am) begin
					edit_minute_d = min_dn_w;
				end else if (enter_ok) begin
					alarm_minute_d = edit_minute_q;
					alarm_on_d     = 1'b1;
					mode_d         = MODE_ARMED;
				end
			end
			MODE_ARMED: begin
				mode_d = MODE_ARMED;
			end
			default: begin
				mode_d = mode_q;
			end
		endcase
	end

	always_comb begin
		combo_p = fired;
		armed_p = enter_ok && ((mode_q == MODE_CONFIRM) || (mode_q == MODE_MINUTE));
		store_p = enter_ok && (mode_q == MODE_MINUTE);
	end

	assign result = {4'b0000, store_p, armed_p, combo_p, alarm_on_d, edit_minute_d,
		edit_hour_d, alarm_minute_d, alarm_hour_d, mode_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_press_q   <= LONG_PRESS_RST;
			repeat_q       <= REPEAT_RST;
			combo_ms_q     <= COMBO_RST;
			lockout_q      <= LOCKOUT_RST;
			step_q         <= STEP_RST;
			saved_hour_q   <= HOUR_RST;
			saved_minute_q <= MINUTE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LONG_PRESS:   long_press_q   <= cfg_data;
				REG_REPEAT:       repeat_q       <= cfg_data;
				REG_COMBO:        combo_ms_q     <= cfg_data;
				REG_LOCKOUT:      lockout_q      <= cfg_data;
				REG_MINUTE_STEP:  step_q         <= cfg_data[4:0];
				REG_SAVED_HOUR:   saved_hour_q   <= cfg_data[4:0];
				REG_SAVED_MINUTE: saved_minute_q <= cfg_data[5:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= MODE_HOUR;
			alarm_hour_q   <= HOUR_RST;
			alarm_minute_q <= MINUTE_RST;
			edit_hour_q    <= HOUR_RST;
			edit_minute_q  <= MINUTE_RST;
			alarm_on_q     <= 1'b0;
			plus_held_q    <= 1'b0;
			minus_held_q   <= 1'b0;
			plus_age_q     <= '0;
			minus_age_q    <= '0;
			since_action_q <= '0;
			since_enter_q  <= TMAX;
			ewr_q          <= 1'b0;
			combo_held_q   <= 1'b0;
			combo_age_q    <= '0;
			combo_done_q   <= 1'b0;
		end else if (reload) begin
			mode_q         <= reload_valid ? MODE_CONFIRM : MODE_HOUR;
			alarm_hour_q   <= reload_valid ? ld_hour : HOUR_RST;
			alarm_minute_q <= reload_valid ? ld_minute : MINUTE_RST;
			edit_hour_q    <= HOUR_RST;
			edit_minute_q  <= MINUTE_RST;
			alarm_on_q     <= 1'b0;
			plus_held_q    <= 1'b0;
			minus_held_q   <= 1'b0;
			plus_age_q     <= '0;
			minus_age_q    <= '0;
			since_action_q <= '0;
			since_enter_q  <= TMAX;
			ewr_q          <= 1'b0;
			combo_held_q   <= 1'b0;
			combo_age_q    <= '0;
			combo_done_q   <= 1'b0;
		end else if (push) begin
			mode_q         <= mode_d;
			alarm_hour_q   <= alarm_hour_d;
			alarm_minute_q <= alarm_minute_d;
			edit_hour_q    <= edit_hour_d;
			edit_minute_q  <= edit_minute_d;
			alarm_on_q     <= alarm_on_d;
			plus_held_q    <= plus_held_d;
			minus_held_q   <= minus_held_d;
			plus_age_q     <= plus_age_d;
			minus_age_q    <= minus_age_d;
			since_action_q <= since_action_d;
			since_enter_q  <= since_enter_d;
			ewr_q          <= ewr_d;
			combo_held_q   <= combo_held_d;
			combo_age_q    <= combo_age_d;
			combo_done_q   <= combo_done_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			sk_valid_q <= 1'b0;
		end else if (pop) begin
			if (sk_valid_q) begin
				sk_valid_q <= 1'b0;
			end else begin
				m_tvalid_q <= push;
			end
		end else if (push) begin
			if (m_tvalid_q) begin
				sk_valid_q <= 1'b1;
			end else begin
				m_tvalid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (sk_valid_q) begin
				m_data_q <= sk_data_q;
			end else if (push) begin
				m_data_q <= result;
			end
		end else if (push) begin
			if (m_tvalid_q) begin
				sk_data_q <= result;
			end else begin
				m_data_q <= result;
			end
		end
	end

	a_skid_behind_main: assert property (@(posedge clk) disable iff (!arst_n)
		sk_valid_q |-> m_tvalid_q)
		else $error("Skid entry is valid while the output entry is empty.");

	a_store_arms: assert property (@(posedge clk) disable iff (!arst_n)
		(push && store_p) |-> (armed_p && (mode_d == MODE_ARMED)))
		else $error("Store pulse without entering armed mode.");

	a_combo_armed: assert property (@(posedge clk) disable iff (!arst_n)
		(push && combo_p) |-> (armed && !ap && !am && !enter_ok))
		else $error("Combo pulse outside armed mode or together with a key action.");

	a_armed_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		((mode_q == MODE_ARMED) && !reload) |=> (mode_q == MODE_ARMED))
		else $error("Armed mode left without a reload.");

endmodule

`default_nettype wire

// File: tb/alarm_tick_sb_pkg.sv
`timescale 1ns / 1ps

package alarm_tick_sb_pkg;
	import ats_pkg::*;

	localparam int TW = TIMER_BITS_DEF;

	typedef struct packed {
		logic       store;
		logic       armed;
		logic       combo;
		logic       on;
		logic [5:0] edit_min;
		logic [4:0] edit_hr;
		logic [5:0] alarm_min;
		logic [4:0] alarm_hr;
		mode_t      mode;
	} tick_view_t;

	class alarm_tick_scoreboard;
		logic [15:0]   long_press, repeat_gap, combo_need, lockout;
		logic [4:0]    step, saved_hr;
		logic [5:0]    saved_min;
		logic          saved_ok;
		mode_t         mode;
		logic [4:0]    alarm_hr, edit_hr;
		logic [5:0]    alarm_min, edit_min;
		logic          on;
		logic          plus_held, minus_held, enter_hold, combo_held, combo_done;
		logic [TW-1:0] plus_age, minus_age, since_act, since_enter, combo_age;
		tick_view_t    due_ticks[$];
		int            errors, checked, n_combo, n_armed, n_store;

		function new();
			long_press = LONG_PRESS_RST;
			repeat_gap = REPEAT_RST;
			combo_need = COMBO_RST;
			lockout = LOCKOUT_RST;
			step = STEP_RST;
			saved_ok = 1'b0;
			saved_hr = HOUR_RST;
			saved_min = MINUTE_RST;
			restart();
		endfunction

		function void restart();
			if (saved_ok) begin
				mode = MODE_CONFIRM;
				alarm_hr = saved_hr % HOURS_PER_DAY;
				alarm_min = saved_min % MINS_PER_HOUR;
			end else begin
				mode = MODE_HOUR;
				alarm_hr = HOUR_RST;
				alarm_min = MINUTE_RST;
			end
			edit_hr = HOUR_RST;
			edit_min = MINUTE_RST;
			on = 1'b0;
			plus_held = 1'b0;
			minus_held = 1'b0;
			enter_hold = 1'b0;
			combo_held = 1'b0;
			combo_done = 1'b0;
			plus_age = '0;
			minus_age = '0;
			since_act = '0;
			combo_age = '0;
			since_enter = '1;
		endfunction

		function void set_reg(logic [7:0] idx, logic [15:0] val);
			case (idx)
			REG_LONG_PRESS:   long_press = val;
			REG_REPEAT:       repeat_gap = val;
			REG_COMBO:        combo_need = val;
			REG_LOCKOUT:      lockout = val;
			REG_MINUTE_STEP:  step = val[4:0];
			REG_SAVED_VALID: begin
				saved_ok = val[0];
				restart();
			end
			REG_SAVED_HOUR:   saved_hr = val[4:0];
			REG_SAVED_MINUTE: saved_min = val[5:0];
			default: ;
			endcase
		endfunction

		function logic [TW-1:0] bump(logic [TW-1:0] t);
			return (&t) ? t : t + 1'b1;
		endfunction

		function logic key_step(logic down, logic other, inout logic held,
				inout logic [TW-1:0] hage);
			if (other)
				return 1'b0;
			if (!down) begin
				held = 1'b0;
				return 1'b0;
			end
			if (!held) begin
				held = 1'b1;
				hage = '0;
				since_act = '0;
				return 1'b1;
			end
			if (hage > long_press && since_act > repeat_gap) begin
				since_act = '0;
				return 1'b1;
			end
			return 1'b0;
		endfunction

		function void take_buttons(logic p, logic m, logic e);
			tick_view_t r;
			logic fired, ap, am, enter_ok;
			r = '0;
			fired = 1'b0;
			ap = 1'b0;
			am = 1'b0;
			enter_ok = 1'b0;
			plus_age = bump(plus_age);
			minus_age = bump(minus_age);
			since_act = bump(since_act);
			since_enter = bump(since_enter);
			combo_age = bump(combo_age);
			if (enter_hold && !e)
				enter_hold = 1'b0;
			if (!enter_hold) begin
				if (mode == MODE_ARMED) begin
					if (p && m) begin
						if (!combo_held) begin
							combo_held = 1'b1;
							combo_age = '0;
						end
						if (!combo_done && combo_age >= combo_need) begin
							combo_done = 1'b1;
							fired = 1'b1;
						end
					end else begin
						combo_held = 1'b0;
						combo_done = 1'b0;
					end
				end
				if (fired) begin
					r.combo = 1'b1;
					plus_held = 1'b0;
					minus_held = 1'b0;
				end else begin
					ap = key_step(p, m, plus_held, plus_age);
					am = key_step(m, p, minus_held, minus_age);
					if (!ap && !am && mode != MODE_ARMED && e && since_enter > lockout) begin
						enter_ok = 1'b1;
						since_enter = '0;
						enter_hold = 1'b1;
					end
					case (mode)
					MODE_CONFIRM: begin
						if (ap || am) begin
							edit_hr = alarm_hr;
							edit_min = alarm_min;
							mode = MODE_HOUR;
						end else if (enter_ok) begin
							on = 1'b1;
							mode = MODE_ARMED;
							r.armed = 1'b1;
						end
					end
					MODE_HOUR: begin
						if (ap)
							edit_hr = (edit_hr == HOURS_PER_DAY - 5'd1) ? '0 : edit_hr + 1'b1;
						else if (am)
							edit_hr = (edit_hr == 5'd0) ? HOURS_PER_DAY - 5'd1 : edit_hr - 1'b1;
						else if (enter_ok) begin
							alarm_hr = edit_hr;
							mode = MODE_MINUTE;
						end
					end
					MODE_MINUTE: begin
						if (ap)
							edit_min = 6'((int'(edit_min) + int'(step)) % 60);
						else if (am)
							edit_min = 6'((int'(edit_min) + 60 - int'(step) % 60) % 60);
						else if (enter_ok) begin
							alarm_min = edit_min;
							on = 1'b1;
							mode = MODE_ARMED;
							r.armed = 1'b1;
							r.store = 1'b1;
						end
					end
					default: ;
					endcase
				end
			end
			r.mode = mode;
			r.alarm_hr = alarm_hr;
			r.alarm_min = alarm_min;
			r.edit_hr = edit_hr;
			r.edit_min = edit_min;
			r.on = on;
			n_combo += r.combo;
			n_armed += r.armed;
			n_store += r.store;
			due_ticks.push_back(r);
		endfunction

		task report(string what);
			if (errors < 40)
				$display("[%0t] MISMATCH: %s", $realtime, what);
			errors++;
		endtask

		task check_display(logic [31:0] got);
			int lo [10] = '{0, 2, 7, 13, 18, 24, 25, 26, 27, 28};
			int wd [10] = '{2, 5, 6, 5, 6, 1, 1, 1, 1, 4};
			string nm [10] = '{"mode", "alarm_hour", "alarm_minute", "edit_hour",
				"edit_minute", "alarm_on", "combo_pulse", "armed_pulse", "store_pulse",
				"zero fill"};
			logic [31:0] want, mask;
			tick_view_t tv;
			if (due_ticks.size() == 0) begin
				report($sformatf("output beat %h arrived with no tick pending", got));
				return;
			end
			tv = due_ticks.pop_front();
			want = {4'b0000, tv};
			for (int i = 0; i < 10; i++) begin
				mask = (32'd1 << wd[i]) - 32'd1;
				if (((got >> lo[i]) & mask) !== ((want >> lo[i]) & mask))
					report($sformatf("beat %0d %s got %0h expected %0h", checked, nm[i],
						(got >> lo[i]) & mask, (want >> lo[i]) & mask));
			end
			checked++;
		endtask
	endclass

endpackage

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import ats_pkg::*;
	import alarm_tick_sb_pkg::*;

	localparam logic [2:0] KEY_IDLE = 3'b000;
	localparam logic [2:0] KEY_INC  = 3'b001;
	localparam logic [2:0] KEY_DEC  = 3'b010;
	localparam logic [2:0] KEY_PAIR = 3'b011;
	localparam logic [2:0] KEY_OK   = 3'b100;
	localparam logic [2:0] KEY_ALL  = 3'b111;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASES = 10;

	localparam logic [2:0] OPENING [27] = '{
		KEY_IDLE, KEY_INC, KEY_INC, KEY_INC, KEY_INC, KEY_INC, KEY_INC, KEY_PAIR,
		KEY_IDLE, KEY_DEC, KEY_DEC, KEY_OK, KEY_OK | KEY_INC, KEY_OK,
		KEY_INC, KEY_OK, KEY_DEC, KEY_OK | KEY_DEC, KEY_IDLE, KEY_OK,
		KEY_IDLE, KEY_PAIR, KEY_PAIR, KEY_PAIR, KEY_PAIR, KEY_ALL, KEY_IDLE};

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	alarm_tick_scoreboard sb;
	int ticks_sent = 0;
	int reg_writes = 0;
	int burst_left = 0;
	int rx_cycle = 0;

	alarm_time_setter_with_key_repeat uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	always @(negedge clk) begin
		rx_cycle++;
		case ((rx_cycle / 150) % 4)
		0: m_tready = 1'b1;
		1: m_tready = ($urandom_range(0, 3) != 0);
		2: m_tready = (rx_cycle % 11 > 3);
		default: m_tready = ($urandom_range(0, 1) == 1);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_display(m_tdata);
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("Timeout after %0d cycles with %0d results outstanding", CYCLE_LIMIT,
			sb.due_ticks.size());
		$display("*** FAILED ***");
		$finish;
	end

	task automatic send_tick(logic [2:0] btn);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
			if (gap > 0) begin
				s_tvalid = 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		s_tvalid = 1'b1;
		s_tdata = {5'b00000, btn};
		do @(posedge clk); while (!s_tready);
		sb.take_buttons(btn[0], btn[1], btn[2]);
		ticks_sent++;
		burst_left--;
		@(negedge clk);
	endtask

	task automatic settle();
		s_tvalid = 1'b0;
		while (sb.due_ticks.size() != 0)
			@(posedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_reg(logic [7:0] idx, logic [15:0] val);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, val);
		reg_writes++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic load_regs(logic [15:0] lp, logic [15:0] rp, logic [15:0] cb,
			logic [15:0] lk, logic [4:0] stp, logic [4:0] hr, logic [5:0] mn, logic sv);
		write_reg(REG_LONG_PRESS, lp);
		write_reg(REG_REPEAT, rp);
		write_reg(REG_COMBO, cb);
		write_reg(REG_LOCKOUT, lk);
		write_reg(REG_MINUTE_STEP, 16'(stp));
		write_reg(REG_SAVED_HOUR, 16'(hr));
		write_reg(REG_SAVED_MINUTE, 16'(mn));
		write_reg(REG_SAVED_VALID, 16'(sv));
	endtask

	function automatic logic [15:0] pick_threshold();
		if ($urandom_range(0, 5) == 0)
			return 16'($urandom_range(1, 65535));
		return 16'($urandom_range(1, 25));
	endfunction

	task automatic setup_phase(int ph);
		logic [4:0] stp;
		case (ph)
		0: load_regs(16'd1, 16'd1, 16'd1, 16'd1, 5'd1, 5'd0, 6'd0, 1'b0);
		1: load_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 5'd30, 5'd23, 6'd59, 1'b1);
		2: load_regs(pick_threshold(), pick_threshold(), pick_threshold(), 16'd4, 5'd0,
			5'($urandom_range(24, 31)), 6'($urandom_range(60, 63)), 1'b1);
		default: begin
			stp = ($urandom_range(0, 5) == 0) ? 5'($urandom_range(0, 31))
				: 5'($urandom_range(1, 30));
			load_regs(pick_threshold(), pick_threshold(), pick_threshold(),
				16'($urandom_range(1, 30)), stp, 5'($urandom_range(0, 31)),
				6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
		end
		endcase
		if ($urandom_range(0, 1) == 1)
			write_reg(REG_SAVED_HOUR, 16'($urandom_range(0, 31)));
		write_reg(8'($urandom_range(int'(REG_SAVED_MINUTE) + 1, 255)), 16'($urandom));
	endtask

	task automatic run_phase(int n);
		int start, kind, len;
		logic [2:0] btn;
		logic noisy;
		start = ticks_sent;
		while (ticks_sent - start < n) begin
			kind = $urandom_range(0, 9);
			noisy = 1'b0;
			len = $urandom_range(1, 6);
			case (kind)
			0, 1: begin
				btn = KEY_INC;
				len = $urandom_range(1, 50);
			end
			2, 3: begin
				btn = KEY_DEC;
				len = $urandom_range(1, 50);
			end
			4: begin
				btn = KEY_PAIR;
				len = $urandom_range(1, 40);
			end
			5, 6: btn = KEY_OK;
			7: begin
				btn = KEY_IDLE;
				len = $urandom_range(1, 20);
			end
			8: begin
				btn = KEY_IDLE;
				noisy = 1'b1;
			end
			default: btn = KEY_OK | 3'($urandom_range(1, 3));
			endcase
			repeat (len)
				send_tick(noisy ? 3'($urandom_range(0, 7)) : btn);
		end
	endtask

	initial begin
		int ph;
		sb = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_tick(KEY_IDLE);
		send_tick(KEY_INC);
		settle();
		load_regs(16'd2, 16'd1, 16'd2, 16'd6, 5'd31, 5'd31, 6'd63, 1'b1);
		foreach (OPENING[i])
			send_tick(OPENING[i]);

		for (ph = 0; ph < PHASES; ph++) begin
			settle();
			setup_phase(ph);
			if (ph == 3) begin
				run_phase(50);
				settle();
				run_phase(55);
			end else begin
				run_phase(105);
			end
		end

		settle();
		repeat (8) @(posedge clk);
		if (sb.due_ticks.size() != 0)
			sb.report($sformatf("%0d expected beats never arrived", sb.due_ticks.size()));
		$display("Sent %0d button ticks under %0d register settings (%0d register writes);",
			ticks_sent, PHASES + 2, reg_writes);
		$display("checked %0d output beats, with %0d combo, %0d armed, %0d store pulses.",
			sb.checked, sb.n_combo, sb.n_armed, sb.n_store);
		if (sb.errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
